>>> rtl/core/elfls_pkg.sv
// ----------------------------------------------------------------------------
// elfls_pkg
// Shared types and constants for the ELF load segment extractor.
// ----------------------------------------------------------------------------
package elfls_pkg;

    localparam int unsigned SizeWidthDefault = 32;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_SMALL     = 3'd2,
        ST_MAGIC     = 3'd3,
        ST_CLASS     = 3'd4,
        ST_ENDIAN    = 3'd5,
        ST_VERSION   = 3'd6
    } status_t;

    typedef enum logic {
        CFG_IMAGE_SIZE = 1'b0,
        CFG_SEG_CAP    = 1'b1
    } cfg_idx_t;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_FINAL   = 1'b1;

    localparam logic [7:0]  ELF_MAG0        = 8'h7f;
    localparam logic [7:0]  ELF_MAG1        = 8'h45;
    localparam logic [7:0]  ELF_MAG2        = 8'h4c;
    localparam logic [7:0]  ELF_MAG3        = 8'h46;
    localparam logic [7:0]  ELFCLASS32      = 8'd1;
    localparam logic [7:0]  ELFCLASS64      = 8'd2;
    localparam logic [7:0]  ELFDATA2LSB     = 8'd1;
    localparam logic [7:0]  ELF_VER_CURRENT = 8'd1;
    localparam logic [15:0] ET_EXEC         = 16'd2;
    localparam logic [15:0] ET_DYN          = 16'd3;
    localparam logic [31:0] PT_LOAD         = 32'd1;

    localparam int unsigned OutDataWidth = 472;

    typedef struct packed {
        logic        kind;
        status_t     status;
        logic [63:0] entry_addr;
        logic [15:0] seg_count;
        logic [63:0] virt_addr;
        logic [63:0] phys_addr;
        logic [63:0] seg_offset;
        logic [63:0] seg_bytes;
        logic [63:0] mem_size;
        logic [31:0] flags;
        logic [31:0] align;
        logic        last;
    } rec_t;

endpackage

>>> rtl/core/elf_load_segment_extractor.sv
// ----------------------------------------------------------------------------
// elf_load_segment_extractor
// Streaming ELF32/ELF64 header and program-header parser emitting PT_LOAD
// segment records and one closing status record per image.
// ----------------------------------------------------------------------------
// Usage:
//   Write image_size (index 0) and segment_capacity (index 1) on the cfg port
//   while idle, then stream the image one byte per word on the s_ side, file
//   order, with s_tlast on the final byte. The m_ side carries records:
//   m_tuser=0 segment record, m_tuser=1 final status record (m_tlast high).
//   Each byte is judged in the cycle it is accepted; its records are registered
//   in a four-deep output queue and are offered on m_tvalid from there.
//   Throughput: one byte per cycle. A byte can produce two records (segment
//   plus closing record), so s_tready drops while fewer than two queue slots
//   are free; the queue drains one record per cycle while m_tready is high.
//   Reset clears the parse state, the registers and the queue. A stall on
//   m_tready fills the queue and then holds s_tready low; nothing is dropped.
//   After the closing record, bytes are swallowed until s_tlast, which rearms
//   the parser for the next image (registers are kept).
// ----------------------------------------------------------------------------
module elf_load_segment_extractor #(
    parameter int unsigned SIZE_WIDTH = elfls_pkg::SizeWidthDefault
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [31:0]                        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // data_byte
    input  logic                               s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status, entry address, segment count, virt_addr, phys_addr,
    // segment offset, segment bytes in file, seg_mem_size, seg_flags,
    // seg_align, zero pad
    output logic [elfls_pkg::OutDataWidth-1:0] m_tdata,
    output logic                               m_tuser,   // result_kind
    output logic                               m_tlast    // last_result
);

    localparam int unsigned SzW = (SIZE_WIDTH < 32) ? SIZE_WIDTH : 32;

    // configuration
    logic [SzW-1:0] image_size_reg;
    logic [15:0]    seg_cap_reg;

    // parse state
    logic [31:0] pos_reg,   pos_next;
    logic        c64_reg,   c64_next;
    logic        done_reg,  done_next;
    logic [15:0] eidx_reg,  eidx_next;
    logic [15:0] ecnt_reg,  ecnt_next;
    logic [15:0] nseg_reg,  nseg_next;
    logic [7:0]  hdr_reg [64];
    logic [7:0]  ent_reg [56];

    // output queue
    elfls_pkg::rec_t fifo_reg [4];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] cnt_reg,  cnt_next;

    logic acc, pop;
    assign acc = s_tvalid && s_tready;
    assign pop = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= '0;
            seg_cap_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (elfls_pkg::cfg_idx_t'(cfg_index))
                elfls_pkg::CFG_IMAGE_SIZE: image_size_reg <= cfg_wdata[SzW-1:0];
                elfls_pkg::CFG_SEG_CAP:    seg_cap_reg    <= cfg_wdata[15:0];
                default:                   seg_cap_reg    <= seg_cap_reg;
            endcase
        end
    end

    // flattened views of the captures
    logic [511:0] hflat;
    logic [447:0] eflat;
    logic [7:0]   b;
    assign b = s_tdata;

    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            hflat[i*8 +: 8] = hdr_reg[i];
        end
        // merge the byte in flight so the last entry byte is seen
        for (int i = 0; i < 56; i++)
        begin
            eflat[i*8 +: 8] = (ecnt_reg == 16'(i)) ? b : ent_reg[i];
        end
    end

    logic [63:0] sz;
    logic [6:0]  hsz;
    logic [63:0] phoff, entry_pt;
    logic [15:0] phent, phnum;
    logic [31:0] pprod;
    logic [63:0] e_off, e_va, e_pa, e_fs, e_ms, e_al;
    logic [31:0] e_fl;

    assign sz    = 64'(image_size_reg);
    assign hsz   = c64_reg ? 7'd64 : 7'd52;
    assign phoff = c64_reg ? hflat[32*8 +: 64] : 64'(hflat[28*8 +: 32]);
    assign phent = c64_reg ? hflat[54*8 +: 16] : hflat[42*8 +: 16];
    assign phnum = c64_reg ? hflat[56*8 +: 16] : hflat[44*8 +: 16];
    assign entry_pt = c64_reg ? hflat[24*8 +: 64] : 64'(hflat[24*8 +: 32]);
    assign pprod = 32'(phent) * 32'(phnum);

    always_comb
    begin
        if (c64_reg)
        begin
            e_fl  = eflat[4*8 +: 32];
            e_off = eflat[8*8 +: 64];
            e_va  = eflat[16*8 +: 64];
            e_pa  = eflat[24*8 +: 64];
            e_fs  = eflat[32*8 +: 64];
            e_ms  = eflat[40*8 +: 64];
            e_al  = eflat[48*8 +: 64];
        end
        else
        begin
            e_off = 64'(eflat[4*8 +: 32]);
            e_va  = 64'(eflat[8*8 +: 32]);
            e_pa  = 64'(eflat[12*8 +: 32]);
            e_fs  = 64'(eflat[16*8 +: 32]);
            e_ms  = 64'(eflat[20*8 +: 32]);
            e_fl  = eflat[24*8 +: 32];
            e_al  = 64'(eflat[28*8 +: 32]);
        end
    end

    // identification checks, first failure wins
    elfls_pkg::status_t id_st;
    always_comb
    begin
        priority if (sz < 64'd16)
            id_st = elfls_pkg::ST_SMALL;
        else if (hdr_reg[0] != elfls_pkg::ELF_MAG0 || hdr_reg[1] != elfls_pkg::ELF_MAG1
                 || hdr_reg[2] != elfls_pkg::ELF_MAG2 || hdr_reg[3] != elfls_pkg::ELF_MAG3)
            id_st = elfls_pkg::ST_MAGIC;
        else if (hdr_reg[4] != elfls_pkg::ELFCLASS32 && hdr_reg[4] != elfls_pkg::ELFCLASS64)
            id_st = elfls_pkg::ST_CLASS;
        else if (hdr_reg[5] != elfls_pkg::ELFDATA2LSB)
            id_st = elfls_pkg::ST_ENDIAN;
        else if (b != elfls_pkg::ELF_VER_CURRENT)
            id_st = elfls_pkg::ST_VERSION;
        else if (sz < 64'(hsz))
            id_st = elfls_pkg::ST_SMALL;
        else
            id_st = elfls_pkg::ST_OK;
    end

    // file header checks
    elfls_pkg::status_t hd_st;
    always_comb
    begin
        priority if (hflat[20*8 +: 32] != 32'(elfls_pkg::ELF_VER_CURRENT))
            hd_st = elfls_pkg::ST_VERSION;
        else if (hflat[16*8 +: 16] != elfls_pkg::ET_EXEC
                 && hflat[16*8 +: 16] != elfls_pkg::ET_DYN)
            hd_st = elfls_pkg::ST_MALFORMED;
        else if (phent < (c64_reg ? 16'd56 : 16'd32))
            hd_st = elfls_pkg::ST_MALFORMED;
        else if (phoff > sz || 64'(pprod) > sz - phoff)
            hd_st = elfls_pkg::ST_MALFORMED;
        else if (phnum != 16'd0 && phoff < 64'(hsz))
            hd_st = elfls_pkg::ST_MALFORMED;
        else
            hd_st = elfls_pkg::ST_OK;
    end

    // entry judgement
    logic e_load, e_bad;
    logic [63:0] al_m1;
    assign al_m1  = e_al - 64'd1;
    assign e_load = (eflat[31:0] == elfls_pkg::PT_LOAD);
    assign e_bad  = (e_off > sz) || (e_fs > sz - e_off) || (e_ms < e_fs)
                  || ((e_al > 64'd1)
                      && (((e_al & al_m1) != 64'd0) || (((e_va ^ e_off) & al_m1) != 64'd0)));

    // per-byte decision
    logic                seg_v, fin_v;
    elfls_pkg::status_t  fin_st;
    logic                in_entry;
    logic [16:0]         ecnt_inc;

    always_comb
    begin
        seg_v     = 1'b0;
        fin_v     = 1'b0;
        fin_st    = elfls_pkg::ST_OK;
        pos_next  = pos_reg;
        c64_next  = c64_reg;
        done_next = done_reg;
        eidx_next = eidx_reg;
        ecnt_next = ecnt_reg;
        nseg_next = nseg_reg;
        in_entry  = 1'b0;
        ecnt_inc  = 17'(ecnt_reg) + 17'd1;

        if (!done_reg)
        begin
            if (pos_reg == 32'd4)
                c64_next = (b == elfls_pkg::ELFCLASS64);

            if (pos_reg == 32'd6)
            begin
                if (id_st != elfls_pkg::ST_OK)
                begin
                    fin_v  = 1'b1;
                    fin_st = id_st;
                end
            end
            else if (pos_reg > 32'd6 && pos_reg == 32'(hsz) - 32'd1)
            begin
                if (hd_st != elfls_pkg::ST_OK)
                begin
                    fin_v  = 1'b1;
                    fin_st = hd_st;
                end
                else if (phnum == 16'd0 || seg_cap_reg == 16'd0)
                    fin_v = 1'b1;
            end
            else if (pos_reg >= 32'(hsz) && 64'(pos_reg) >= phoff)
            begin
                in_entry  = 1'b1;
                ecnt_next = ecnt_inc[15:0];
                if (ecnt_inc >= 17'(phent))
                begin
                    ecnt_next = '0;
                    eidx_next = eidx_reg + 16'd1;
                    if (e_load && e_bad)
                    begin
                        fin_v  = 1'b1;
                        fin_st = elfls_pkg::ST_MALFORMED;
                    end
                    else
                    begin
                        if (e_load)
                        begin
                            seg_v     = 1'b1;
                            nseg_next = nseg_reg + 16'd1;
                        end
                        if (nseg_next >= seg_cap_reg || eidx_next >= phnum)
                            fin_v = 1'b1;
                    end
                end
            end

            if (pos_reg != 32'hffff_ffff)
                pos_next = pos_reg + 32'd1;
            if (fin_v)
                done_next = 1'b1;
        end

        // end of the image: an early end closes with ST_SMALL, every end rearms
        if (s_tlast)
        begin
            if (!done_next)
            begin
                fin_v  = 1'b1;
                fin_st = elfls_pkg::ST_SMALL;
            end
            pos_next  = '0;
            c64_next  = 1'b0;
            done_next = 1'b0;
            eidx_next = '0;
            ecnt_next = '0;
            nseg_next = '0;
        end
    end

    // records
    elfls_pkg::rec_t seg_rec, fin_rec;
    always_comb
    begin
        seg_rec            = '0;
        seg_rec.kind       = elfls_pkg::KIND_SEGMENT;
        seg_rec.virt_addr  = e_va;
        seg_rec.phys_addr  = e_pa;
        seg_rec.seg_offset = e_off;
        seg_rec.seg_bytes  = e_fs;
        seg_rec.mem_size   = e_ms;
        seg_rec.flags      = e_fl;
        seg_rec.align      = e_al[31:0];

        fin_rec        = '0;
        fin_rec.kind   = elfls_pkg::KIND_FINAL;
        fin_rec.status = fin_st;
        fin_rec.last   = 1'b1;
        if (fin_st == elfls_pkg::ST_OK)
        begin
            fin_rec.entry_addr = entry_pt;
            fin_rec.seg_count  = seg_v ? nseg_reg + 16'd1 : nseg_reg;
        end
    end

    // capture stores, written only while parsing
    always_ff @(posedge clk)
    begin
        if (acc && !done_reg)
        begin
            if (pos_reg < 32'd64)
                hdr_reg[pos_reg[5:0]] <= b;
            if (in_entry && ecnt_reg < 16'd56)
                ent_reg[ecnt_reg[5:0]] <= b;
        end
    end

    logic push2;
    logic [1:0] npush;
    assign push2 = seg_v && fin_v;
    assign npush = acc ? (2'(seg_v) + 2'(fin_v)) : 2'd0;
    assign cnt_next = cnt_reg + 3'(npush) - 3'(pop);

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            if (seg_v)
                fifo_reg[wptr_reg] <= seg_rec;
            if (fin_v)
                fifo_reg[push2 ? wptr_reg + 2'd1 : wptr_reg] <= fin_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            c64_reg  <= 1'b0;
            done_reg <= 1'b0;
            eidx_reg <= '0;
            ecnt_reg <= '0;
            nseg_reg <= '0;
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (acc)
            begin
                pos_reg  <= pos_next;
                c64_reg  <= c64_next;
                done_reg <= done_next;
                eidx_reg <= eidx_next;
                ecnt_reg <= ecnt_next;
                nseg_reg <= nseg_next;
            end
            wptr_reg <= wptr_reg + npush;
            if (pop)
                rptr_reg <= rptr_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

    // outputs: accept a byte only while at least two slots are free
    elfls_pkg::rec_t head;
    assign head     = fifo_reg[rptr_reg];
    assign s_tready = (cnt_reg <= 3'd2);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {5'd0, head.align, head.flags, head.mem_size, head.seg_bytes,
                       head.seg_offset, head.phys_addr, head.virt_addr,
                       head.seg_count, head.entry_addr, head.status};

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("output queue overflow");

    // only the closing record ends an image
    assert property (@(posedge clk) disable iff (!rst_n)
                     m_tvalid |-> (m_tlast == (m_tuser == elfls_pkg::KIND_FINAL)))
        else $error("record kind and last flag disagree");

    // a segment record always carries status ok
    assert property (@(posedge clk) disable iff (!rst_n)
                     (m_tvalid && m_tuser == elfls_pkg::KIND_SEGMENT)
                     |-> (head.status == elfls_pkg::ST_OK))
        else $error("segment record with error status");

endmodule

>>> tb/sv/elf_load_segment_extractor_tb.sv
// ----------------------------------------------------------------------------
// elf_load_segment_extractor_tb
// Streams generated ELF32/ELF64 images through the extractor and checks each
// segment and closing record against an in-bench parser of the same format.
// ----------------------------------------------------------------------------
module elf_load_segment_extractor_tb;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } img_byte_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    elfls_pkg::cfg_idx_t                cfg_index;
    logic [31:0]                        cfg_wdata;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [7:0]                         s_tdata;   // data_byte
    logic                               s_tlast;   // last_byte
    logic                               m_tvalid;
    logic                               m_tready;
    // status, entry address, segment count, virt_addr, phys_addr,
    // segment offset, segment bytes in file, seg_mem_size, seg_flags,
    // seg_align, zero pad
    logic [elfls_pkg::OutDataWidth-1:0] m_tdata;
    logic                               m_tuser;   // result_kind
    logic                               m_tlast;   // last_result

    elf_load_segment_extractor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Parser state mirrored in the bench
    // ------------------------------------------------------------------
    logic [31:0] pm_size;
    logic [15:0] pm_cap;
    logic [31:0] pm_pos;
    logic        pm_c64;
    logic [7:0]  pm_hdr [64];
    logic [31:0] pm_eidx;
    logic [15:0] pm_ecnt;
    logic [7:0]  pm_ent [56];
    logic [15:0] pm_nseg;
    logic        pm_done;

    elfls_pkg::rec_t rec_q [$];     // records still to come from the block
    img_byte_t       byte_q [$];    // words waiting for the driver
    logic [7:0]      img [$];       // image under construction

    int n_err;
    int n_sent;
    int n_acc;
    int n_cycle;
    int n_images;
    int n_segs;
    int n_finals;
    int n_words;
    logic taken;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("MISMATCH %0s: got %h expected %h (cycle %0d)", what, got, exp, n_cycle);
        n_err++;
    endtask

    function automatic logic [63:0] hdr_le(input int off, input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v[8*i +: 8] = pm_hdr[off + i];
        return v;
    endfunction

    function automatic logic [63:0] ent_le(input int off, input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v[8*i +: 8] = pm_ent[off + i];
        return v;
    endfunction

    function automatic logic [31:0] hdr_len();
        return pm_c64 ? 32'd64 : 32'd52;
    endfunction

    function automatic logic [63:0] tbl_off();
        return pm_c64 ? hdr_le(32, 8) : hdr_le(28, 4);
    endfunction

    function automatic logic [31:0] tbl_ent();
        return 32'(hdr_le(pm_c64 ? 54 : 42, 2));
    endfunction

    function automatic logic [31:0] tbl_num();
        return 32'(hdr_le(pm_c64 ? 56 : 44, 2));
    endfunction

    task automatic close_image(input elfls_pkg::status_t st);
        elfls_pkg::rec_t r;
        r = '0;
        r.kind = elfls_pkg::KIND_FINAL;
        r.status = st;
        if (st == elfls_pkg::ST_OK)
        begin
            r.entry_addr = pm_c64 ? hdr_le(24, 8) : hdr_le(24, 4);
            r.seg_count = pm_nseg;
        end
        r.last = 1'b1;
        rec_q.push_back(r);
        pm_done = 1'b1;
    endtask

    function automatic elfls_pkg::status_t ident_status();
        if (pm_size < 16) return elfls_pkg::ST_SMALL;
        if (pm_hdr[0] != elfls_pkg::ELF_MAG0 || pm_hdr[1] != elfls_pkg::ELF_MAG1
            || pm_hdr[2] != elfls_pkg::ELF_MAG2 || pm_hdr[3] != elfls_pkg::ELF_MAG3)
            return elfls_pkg::ST_MAGIC;
        if (pm_hdr[4] != elfls_pkg::ELFCLASS32 && pm_hdr[4] != elfls_pkg::ELFCLASS64)
            return elfls_pkg::ST_CLASS;
        if (pm_hdr[5] != elfls_pkg::ELFDATA2LSB) return elfls_pkg::ST_ENDIAN;
        if (pm_hdr[6] != elfls_pkg::ELF_VER_CURRENT) return elfls_pkg::ST_VERSION;
        if (pm_size < hdr_len()) return elfls_pkg::ST_SMALL;
        return elfls_pkg::ST_OK;
    endfunction

    function automatic elfls_pkg::status_t header_status();
        logic [63:0] sz;
        logic [63:0] off;
        logic [63:0] span;
        logic [15:0] ftype;
        sz = {32'd0, pm_size};
        off = tbl_off();
        span = 64'(tbl_ent()) * 64'(tbl_num());
        ftype = 16'(hdr_le(16, 2));
        if (hdr_le(20, 4) != 64'd1) return elfls_pkg::ST_VERSION;
        if (ftype != elfls_pkg::ET_EXEC && ftype != elfls_pkg::ET_DYN)
            return elfls_pkg::ST_MALFORMED;
        if (tbl_ent() < (pm_c64 ? 32'd56 : 32'd32)) return elfls_pkg::ST_MALFORMED;
        if (off > sz || span > sz - off) return elfls_pkg::ST_MALFORMED;
        // table overlapping the file header counts as malformed
        if (tbl_num() != 0 && off < 64'(hdr_len())) return elfls_pkg::ST_MALFORMED;
        return elfls_pkg::ST_OK;
    endfunction

    // Judge one captured entry; return 1 when it closes the image.
    task automatic judge_entry(output logic stop);
        logic [63:0] sz, off, va, pa, fs, ms, al;
        logic [31:0] fl;
        elfls_pkg::rec_t r;
        stop = 1'b0;
        sz = {32'd0, pm_size};
        if (ent_le(0, 4) != {32'd0, elfls_pkg::PT_LOAD}) return;
        if (pm_c64)
        begin
            fl = 32'(ent_le(4, 4));
            off = ent_le(8, 8);
            va = ent_le(16, 8);
            pa = ent_le(24, 8);
            fs = ent_le(32, 8);
            ms = ent_le(40, 8);
            al = ent_le(48, 8);
        end
        else
        begin
            off = ent_le(4, 4);
            va = ent_le(8, 4);
            pa = ent_le(12, 4);
            fs = ent_le(16, 4);
            ms = ent_le(20, 4);
            fl = 32'(ent_le(24, 4));
            al = ent_le(28, 4);
        end
        if (off > sz || fs > sz - off || ms < fs
            || (al > 1 && ((al & (al - 1)) != 0 || ((va ^ off) & (al - 1)) != 0)))
        begin
            close_image(elfls_pkg::ST_MALFORMED);
            stop = 1'b1;
            return;
        end
        r = '0;
        r.kind = elfls_pkg::KIND_SEGMENT;
        r.status = elfls_pkg::ST_OK;
        r.virt_addr = va;
        r.phys_addr = pa;
        r.seg_offset = off;
        r.seg_bytes = fs;
        r.mem_size = ms;
        r.flags = fl;
        r.align = al[31:0];
        rec_q.push_back(r);
        pm_nseg++;
    endtask

    task automatic rearm();
        pm_pos = '0;
        pm_c64 = 1'b0;
        pm_eidx = '0;
        pm_ecnt = '0;
        pm_nseg = '0;
        pm_done = 1'b0;
    endtask

    // Advance the mirrored parser by one accepted word.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        elfls_pkg::status_t st;
        logic [31:0] cnt;
        logic stop;
        if (!pm_done)
        begin
            if (pm_pos < 64) pm_hdr[pm_pos[5:0]] = b;
            if (pm_pos == 4) pm_c64 = (b == elfls_pkg::ELFCLASS64);
            if (pm_pos == 6)
            begin
                st = ident_status();
                if (st != elfls_pkg::ST_OK) close_image(st);
            end
            else if (pm_pos > 6 && pm_pos == hdr_len() - 1)
            begin
                st = header_status();
                if (st != elfls_pkg::ST_OK) close_image(st);
                else if (tbl_num() == 0 || pm_cap == 0) close_image(elfls_pkg::ST_OK);
            end
            else if (pm_pos >= hdr_len() && {32'd0, pm_pos} >= tbl_off())
            begin
                cnt = 32'(pm_ecnt);
                if (cnt < 56) pm_ent[cnt[5:0]] = b;
                cnt++;
                if (cnt >= tbl_ent())
                begin
                    cnt = 0;
                    pm_eidx++;
                    judge_entry(stop);
                    if (!stop && (pm_nseg >= pm_cap || pm_eidx >= tbl_num()))
                        close_image(elfls_pkg::ST_OK);
                end
                pm_ecnt = cnt[15:0];
            end
            if (pm_pos != 32'hFFFF_FFFF) pm_pos++;
        end
        if (last)
        begin
            if (!pm_done) close_image(elfls_pkg::ST_SMALL);
            rearm();
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, ready generator and monitor
    // ------------------------------------------------------------------
    function automatic logic quiet();
        // long stretch with no idling on either side
        return n_cycle >= 900 && n_cycle < 1700;
    endfunction

    always @(posedge clk)
    begin
        n_cycle <= n_cycle + 1;
        taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            parse_byte(s_tdata, s_tlast);
            n_acc <= n_acc + 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || taken)
            begin
                if (byte_q.size() > 0 && (quiet() || $urandom_range(0, 99) >= 20))
                begin
                    s_tdata <= byte_q[0].data;
                    s_tlast <= byte_q[0].last;
                    s_tvalid <= 1'b1;
                    void'(byte_q.pop_front());
                    n_sent <= n_sent + 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= quiet() || $urandom_range(0, 99) >= 20;
        end
    end

    // Check each accepted record against the oldest expectation.
    always @(posedge clk)
    begin
        elfls_pkg::rec_t got;
        elfls_pkg::rec_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '0;
            got.kind = m_tuser;
            got.status = elfls_pkg::status_t'(m_tdata[2:0]);
            got.entry_addr = m_tdata[66:3];
            got.seg_count = m_tdata[82:67];
            got.virt_addr = m_tdata[146:83];
            got.phys_addr = m_tdata[210:147];
            got.seg_offset = m_tdata[274:211];
            got.seg_bytes = m_tdata[338:275];
            got.mem_size = m_tdata[402:339];
            got.flags = m_tdata[434:403];
            got.align = m_tdata[466:435];
            got.last = m_tlast;
            if (rec_q.size() == 0)
                report("unexpected record", {63'd0, got.kind}, 64'd0);
            else
            begin
                exp = rec_q.pop_front();
                if (got.kind == elfls_pkg::KIND_FINAL) n_finals++;
                else n_segs++;
                if (got.kind != exp.kind)
                    report("kind", 64'(got.kind), 64'(exp.kind));
                if (got.status != exp.status)
                    report("status", 64'(got.status), 64'(exp.status));
                if (got.entry_addr != exp.entry_addr)
                    report("entry address", got.entry_addr, exp.entry_addr);
                if (got.seg_count != exp.seg_count)
                    report("segment count", 64'(got.seg_count), 64'(exp.seg_count));
                if (got.virt_addr != exp.virt_addr)
                    report("virt_addr", got.virt_addr, exp.virt_addr);
                if (got.phys_addr != exp.phys_addr)
                    report("phys_addr", got.phys_addr, exp.phys_addr);
                if (got.seg_offset != exp.seg_offset)
                    report("segment offset", got.seg_offset, exp.seg_offset);
                if (got.seg_bytes != exp.seg_bytes)
                    report("segment bytes", got.seg_bytes, exp.seg_bytes);
                if (got.mem_size != exp.mem_size)
                    report("mem_size", got.mem_size, exp.mem_size);
                if (got.flags != exp.flags)
                    report("flags", 64'(got.flags), 64'(exp.flags));
                if (got.align != exp.align)
                    report("align", 64'(got.align), 64'(exp.align));
                if (got.last != exp.last)
                    report("last", 64'(got.last), 64'(exp.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Image construction
    // ------------------------------------------------------------------
    task automatic put_le(input int off, input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            if (off + i < img.size()) img[off + i] = v[8*i +: 8];
    endtask

    // Build a well-formed image; hoff moves the table start off its usual spot.
    task automatic make_image(input logic c64, input int pnum, input int hoff);
        int hs, pent, phoff, len, base, k;
        logic [63:0] off, fs, ms, al, va;
        hs = c64 ? 64 : 52;
        pent = c64 ? 56 : 32;
        if ($urandom_range(0, 7) == 0) pent += 8 * int'($urandom_range(1, 2));
        phoff = hs + hoff;
        len = phoff + pent * pnum + int'($urandom_range(0, 24));
        img.delete();
        for (int i = 0; i < len; i++)
            img.push_back(8'($urandom_range(0, 255)));
        put_le(0, {32'd0, elfls_pkg::ELF_MAG3, elfls_pkg::ELF_MAG2,
                   elfls_pkg::ELF_MAG1, elfls_pkg::ELF_MAG0}, 4);
        img[4] = c64 ? elfls_pkg::ELFCLASS64 : elfls_pkg::ELFCLASS32;
        img[5] = elfls_pkg::ELFDATA2LSB;
        img[6] = elfls_pkg::ELF_VER_CURRENT;
        put_le(16, 64'($urandom_range(0, 1) ? elfls_pkg::ET_EXEC : elfls_pkg::ET_DYN), 2);
        put_le(20, 64'd1, 4);
        put_le(24, {$urandom, $urandom}, c64 ? 8 : 4);
        put_le(c64 ? 32 : 28, 64'(phoff), c64 ? 8 : 4);
        put_le(c64 ? 54 : 42, 64'(pent), 2);
        put_le(c64 ? 56 : 44, 64'(pnum), 2);
        for (int e = 0; e < pnum; e++)
        begin
            base = phoff + e * pent;
            put_le(base, ($urandom_range(0, 3) != 0) ? 64'(elfls_pkg::PT_LOAD)
                                                     : 64'($urandom_range(0, 6)), 4);
            off = 64'($urandom_range(0, len));
            fs = 64'($urandom_range(0, len - int'(off)));
            ms = fs + 64'($urandom_range(0, 4096));
            k = $urandom_range(0, 13);
            al = (k == 13) ? 64'd0 : (64'd1 << k);
            va = ({$urandom, $urandom} & ~(al - 1)) | (off & (al - 1));
            if (c64)
            begin
                put_le(base + 4, 64'($urandom), 4);
                put_le(base + 8, off, 8);
                put_le(base + 16, va, 8);
                put_le(base + 24, {$urandom, $urandom}, 8);
                put_le(base + 32, fs, 8);
                put_le(base + 40, ms, 8);
                put_le(base + 48, al, 8);
            end
            else
            begin
                put_le(base + 4, off, 4);
                put_le(base + 8, va, 4);
                put_le(base + 12, 64'($urandom), 4);
                put_le(base + 16, fs, 4);
                put_le(base + 20, ms, 4);
                put_le(base + 24, 64'($urandom), 4);
                put_le(base + 28, al, 4);
            end
        end
    endtask

    // Wait for the block to drain, program both registers, queue the image.
    task automatic run_image(input logic [31:0] size_reg, input logic [15:0] cap);
        img_byte_t w;
        wait (byte_q.size() == 0 && n_sent == n_acc && rec_q.size() == 0);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= elfls_pkg::CFG_IMAGE_SIZE;
        cfg_wdata <= size_reg;
        pm_size = size_reg;
        @(negedge clk);
        cfg_index <= elfls_pkg::CFG_SEG_CAP;
        cfg_wdata <= {16'd0, cap};
        pm_cap = cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        for (int i = 0; i < img.size(); i++)
        begin
            w.data = img[i];
            w.last = (i == img.size() - 1);
            byte_q.push_back(w);
        end
        n_words += img.size();
        n_images++;
    endtask

    initial
    begin
        int n_rand;
        int pick;
        int pnum;
        logic [31:0] sz;
        n_err = 0;
        n_sent = 0;
        n_acc = 0;
        n_cycle = 0;
        n_images = 0;
        n_segs = 0;
        n_finals = 0;
        n_words = 0;
        taken = 1'b0;
        cfg_we = 1'b0;
        cfg_index = elfls_pkg::CFG_IMAGE_SIZE;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        pm_size = '0;
        pm_cap = '0;
        for (int i = 0; i < 64; i++) pm_hdr[i] = '0;
        for (int i = 0; i < 56; i++) pm_ent[i] = '0;
        rearm();
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed: clean 32 and 64 bit images
        make_image(1'b0, 2, 0);
        run_image(32'(img.size()), 16'hFFFF);
        make_image(1'b1, 3, 0);
        run_image(32'(img.size()), 16'hFFFF);
        // no entries, then capacity zero
        make_image(1'b1, 0, 0);
        run_image(32'(img.size()), 16'd4);
        make_image(1'b0, 2, 0);
        run_image(32'(img.size()), 16'd0);
        // capacity reached on the first segment
        make_image(1'b0, 3, 0);
        put_le(52, 64'(elfls_pkg::PT_LOAD), 4);
        put_le(52 + 28, 64'd1, 4);
        run_image(32'(img.size()), 16'd1);
        // size register below the identification block and below the header
        make_image(1'b0, 1, 0);
        run_image(32'd15, 16'd1);
        make_image(1'b1, 1, 0);
        run_image(32'd60, 16'd1);
        // largest size register
        make_image(1'b1, 2, 0);
        run_image(32'hFFFF_FFFF, 16'd2);
        // bad magic, class, encoding, ident version, header version
        make_image(1'b0, 1, 0);
        img[2] = 8'h00;
        run_image(32'(img.size()), 16'd1);
        make_image(1'b0, 1, 0);
        img[4] = 8'd3;
        run_image(32'(img.size()), 16'd1);
        make_image(1'b1, 1, 0);
        img[5] = 8'd2;
        run_image(32'(img.size()), 16'd1);
        make_image(1'b1, 1, 0);
        img[6] = 8'd0;
        run_image(32'(img.size()), 16'd1);
        make_image(1'b0, 1, 0);
        put_le(20, 64'd2, 4);
        run_image(32'(img.size()), 16'd1);
        // table starting inside the file header
        make_image(1'b1, 1, 0);
        put_le(32, 64'd40, 8);
        run_image(32'(img.size()), 16'd1);
        // image ends before any record: single word, and a cut header
        img.delete();
        img.push_back(8'h7f);
        run_image(32'd1, 16'd1);
        make_image(1'b1, 2, 0);
        img = img[0:29];
        run_image(32'd200, 16'd2);
        // segment outside the file
        make_image(1'b0, 1, 0);
        put_le(52, 64'(elfls_pkg::PT_LOAD), 4);
        put_le(56, 64'hFFFF_0000, 4);
        run_image(32'(img.size()), 16'd1);

        // random part: mostly valid images with random content, some broken
        n_rand = 0;
        while (n_words < 1900 || n_rand < 4)
        begin
            pnum = int'($urandom_range(0, 4));
            make_image(1'($urandom_range(0, 1)), pnum,
                       ($urandom_range(0, 15) == 0) ? -int'($urandom_range(4, 40))
                                                    : 4 * int'($urandom_range(0, 3)));
            sz = 32'(img.size());
            pick = int'($urandom_range(0, 19));
            if (pick == 0)
            begin
                img.delete();
                for (int i = $urandom_range(1, 40); i > 0; i--)
                    img.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick <= 2)
                img[$urandom_range(0, img.size() > 64 ? 63 : img.size() - 1)] ^=
                    8'($urandom_range(1, 255));
            else if (pick <= 4)
                img[$urandom_range(0, img.size() - 1)] ^= 8'($urandom_range(1, 255));
            else if (pick == 5)
                img = img[0:$urandom_range(0, img.size() - 1)];
            else if (pick == 6)
                sz = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 400);
            n_rand++;
            run_image(sz, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 5)) :
                          ($urandom_range(0, 1) ? 16'hFFFF : 16'(pnum + 1)));
        end

        wait (byte_q.size() == 0 && n_sent == n_acc && rec_q.size() == 0);
        repeat (20) @(negedge clk);
        $display("ran %0d images, %0d words; checked %0d segment and %0d closing records",
                 n_images, n_acc, n_segs, n_finals);
        if (n_err == 0 && rec_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d records outstanding", rec_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
